[hw/rtl/convex_hull_containment_test_defines.svh]
// Shared assertion macros. Each expects clk and rst_n in the enclosing scope.
`ifndef CONVEX_HULL_CONTAINMENT_TEST_DEFINES_SVH
`define CONVEX_HULL_CONTAINMENT_TEST_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CHCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CHCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/chct_pkg.sv]
package chct_pkg;

  // Sizing of the hull store and the coordinate format.
  localparam int HULL_MAX   = 16;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(HULL_MAX);
  localparam int CNT_W      = $clog2(HULL_MAX + 1);

  // Fixed field widths.
  localparam int VIDX_W     = 4;
  localparam int VCNT_W     = 5;
  localparam int TOL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Arithmetic widths: edge and offset differences, products, check sum.
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 2;

  // Reset values of the configuration registers.
  localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(3);
  localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(3277);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = CFG_IDX_W'(1);

  // Item function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                         func;
    logic [VIDX_W-1:0]            vertex_index;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic                         last_point;
  } chct_in_t;

  typedef struct packed {
    logic inside_res;
    logic all_inside;
    logic set_done;
  } chct_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } vertex_t;

  // Sequencer steps, in program order.
  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_WRAP,
    S_DR1,
    S_DR2,
    S_DR3,
    S_FINISH
  } step_t;

  // Jump conditions of the control word.
  typedef enum logic [1:0] {
    C_NEXT,
    C_START,
    C_LOOP,
    C_OUT
  } cond_t;

  // One control word of the program.
  typedef struct packed {
    logic  in_rdy;
    logic  rd_en;
    logic  rd_zero;
    logic  out_load;
    cond_t cond;
    step_t target;
  } uword_t;

  // Sequencer to datapath control.
  typedef struct packed {
    logic             start;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } chct_ctrl_t;

  // The program. Vertices 0..n-1 are read in turn, then vertex 0 again so
  // the closing edge comes out of the same pipeline.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{in_rdy: 1'b0, rd_en: 1'b0, rd_zero: 1'b0, out_load: 1'b0,
          cond: C_NEXT, target: S_IDLE};
    case (s)
      S_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = C_START;
        w.target = S_FINISH;
      end
      S_WALK: begin
        w.rd_en  = 1'b1;
        w.cond   = C_LOOP;
        w.target = S_WRAP;
      end
      S_WRAP: begin
        w.rd_en   = 1'b1;
        w.rd_zero = 1'b1;
      end
      S_DR1, S_DR2, S_DR3: begin
        w.cond = C_NEXT;
      end
      S_FINISH: begin
        w.out_load = 1'b1;
        w.cond     = C_OUT;
        w.target   = S_IDLE;
      end
      default: begin
        w.cond   = C_OUT;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/chct_seq.sv]
module chct_seq
  import chct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  chct_in_t         in_data,
  input  logic             out_free,
  input  logic [CNT_W-1:0] n_eff,
  output logic             in_ready,
  output logic             out_load,
  output chct_ctrl_t       ctrl
);

  step_t            step_r, step_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  uword_t           uw;
  logic             accept;
  logic             start;
  logic             cnt_last;

  // Fetch the control word of the current step.
  assign uw = ucode(step_r);

  assign in_ready = uw.in_rdy;
  assign accept   = in_valid && uw.in_rdy;
  assign start    = accept && (in_data.func == FUNC_QUERY);
  assign cnt_last = (CNT_W'(cnt_r) == (n_eff - CNT_W'(1)));
  assign out_load = uw.out_load && out_free;

  // Datapath control for this step.
  always_comb begin
    ctrl.start   = start;
    ctrl.wr_en   = accept && (in_data.func == FUNC_LOAD) &&
                   (int'(in_data.vertex_index) < HULL_MAX);
    ctrl.rd_en   = uw.rd_en;
    ctrl.rd_addr = uw.rd_zero ? '0 : cnt_r;
  end

  // Step sequencing and the vertex counter.
  always_comb begin
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    case (uw.cond)
      C_NEXT: begin
        step_nxt = step_t'(step_r + 3'd1);
      end
      C_START: begin
        if (start) begin
          cnt_nxt  = '0;
          step_nxt = (n_eff == '0) ? uw.target : step_t'(step_r + 3'd1);
        end
      end
      C_LOOP: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_last) begin
          step_nxt = uw.target;
        end
      end
      C_OUT: begin
        if (out_free) begin
          step_nxt = uw.target;
        end
      end
      default: begin
        step_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
      cnt_r  <= '0;
    end else begin
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/chct_datapath.sv]
module chct_datapath
  import chct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  chct_ctrl_t       ctrl,
  input  chct_in_t         in_data,
  input  logic [TOL_W-1:0] tolerance,
  output logic             pt_in
);

  vertex_t mem [HULL_MAX];

  vertex_t                      rdata_r;
  vertex_t                      prev_r;
  logic                         rv_r;
  logic                         have_prev_r;
  logic                         dv_r;
  logic                         mv_r;
  logic                         inside_r;
  logic signed [COORD_BITS-1:0] py_r, pz_r;
  logic signed [DIFF_W-1:0]     ey_r, ez_r, dy_r, dz_r;
  logic signed [PROD_W-1:0]     pa_r, pb_r;

  logic signed [DIFF_W-1:0]     cy, cz, vy, vz, qy, qz;
  logic signed [SUM_W-1:0]      sum;

  assign pt_in = inside_r;

  // Hull store: one write port for load items, one registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[IDX_W'(in_data.vertex_index)] <= '{y: in_data.coord_y, z: in_data.coord_z};
    end
    if (ctrl.rd_en) begin
      rdata_r <= mem[ctrl.rd_addr];
    end
  end

  // Sign-extended operands of the difference stage.
  always_comb begin
    cy = rdata_r.y;
    cz = rdata_r.z;
    vy = prev_r.y;
    vz = prev_r.z;
    qy = py_r;
    qz = pz_r;
  end

  // Edge cross product plus tolerance; negative means outside this edge.
  always_comb begin
    sum = SUM_W'(pa_r) - SUM_W'(pb_r) + SUM_W'(signed'({1'b0, tolerance}));
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r        <= 1'b0;
      dv_r        <= 1'b0;
      mv_r        <= 1'b0;
      have_prev_r <= 1'b0;
      inside_r    <= 1'b1;
    end else begin
      rv_r <= ctrl.rd_en;
      dv_r <= rv_r && have_prev_r;
      mv_r <= dv_r;
      if (ctrl.start) begin
        have_prev_r <= 1'b0;
        inside_r    <= 1'b1;
      end else begin
        if (rv_r) begin
          have_prev_r <= 1'b1;
        end
        if (mv_r && sum[SUM_W-1]) begin
          inside_r <= 1'b0;
        end
      end
    end
  end

  // Payload stages: point, previous vertex, differences, products.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      py_r <= in_data.coord_y;
      pz_r <= in_data.coord_z;
    end
    if (rv_r) begin
      prev_r <= rdata_r;
      ey_r   <= cy - vy;
      ez_r   <= cz - vz;
      dy_r   <= qy - vy;
      dz_r   <= qz - vz;
    end
    if (dv_r) begin
      pa_r <= ey_r * dz_r;
      pb_r <= ez_r * dy_r;
    end
  end

endmodule

[hw/rtl/convex_hull_containment_test.sv]
// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_ready      in_data (chct_in_t)
// out      output     out_valid / out_ready    out_data (chct_out_t)
// cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A load item gives no result. A query is accepted, then reads the hull store
// n + 1 times (n the vertex count in use; no reads at zero), drains the edge pipe
// in three steps (S_DR1..S_DR3) and loads the result.
// Reset is synchronous, active low; the hull store holds no reset value.
// A result waits in the output register; a query that finishes while it waits
// stalls until out_ready takes it. Configuration writes are always taken.
module convex_hull_containment_test
  import chct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  chct_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output chct_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [VCNT_W-1:0] vcount_r;
  logic [TOL_W-1:0]  tol_r;
  logic              out_valid_r, out_valid_nxt;
  chct_out_t         out_data_r, out_data_nxt;
  logic              set_all_r, set_all_nxt;
  logic              last_r;
  logic [CNT_W-1:0]  n_eff;
  logic              out_free;
  logic              out_load;
  logic              pt_in;
  chct_ctrl_t        ctrl;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Counts above the store depth use the whole store.
  assign n_eff = (int'(vcount_r) > HULL_MAX) ? CNT_W'(HULL_MAX) : CNT_W'(vcount_r);

  chct_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .out_free (out_free),
    .n_eff    (n_eff),
    .in_ready (in_ready),
    .out_load (out_load),
    .ctrl     (ctrl)
  );

  chct_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_data   (in_data),
    .tolerance (tol_r),
    .pt_in     (pt_in)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCNT_RESET;
      tol_r    <= TOL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VERTEX_COUNT: vcount_r <= cfg_data[VCNT_W-1:0];
        REG_TOLERANCE:    tol_r    <= cfg_data[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Result item and the running flag of the current set.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    set_all_nxt   = set_all_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.inside_res = pt_in;
      out_data_nxt.all_inside = set_all_r && pt_in;
      out_data_nxt.set_done   = last_r;
      set_all_nxt             = last_r || (set_all_r && pt_in);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      set_all_r   <= 1'b1;
    end else begin
      out_valid_r <= out_valid_nxt;
      set_all_r   <= set_all_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (ctrl.start) begin
      last_r <= in_data.last_point;
    end
  end

endmodule

[hw/rtl/chct_checker.sv]
`include "convex_hull_containment_test_defines.svh"

module chct_checker
  import chct_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input chct_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input chct_out_t out_data
);

  // A stalled result holds its value.
  `CHCT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // A point that is outside always clears the running set flag.
  `CHCT_ASSERT_IMP(a_flag_order, out_valid && !out_data.inside_res, !out_data.all_inside, "set reported inside with an outside point")

  // A query keeps the input closed while its edges are walked.
  `CHCT_ASSERT_NXT(a_query_busy, in_valid && in_ready && (in_data.func == FUNC_QUERY), !in_ready, "input open during a query")

  // A load item never produces a result.
  `CHCT_ASSERT_NXT(a_load_silent, in_valid && in_ready && (in_data.func == FUNC_LOAD) && !out_valid, !out_valid, "result after a load item")

endmodule

bind convex_hull_containment_test chct_checker u_chct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import chct_pkg::*;

  // Registers that the block decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam int N_DIRECTED    = 25;
  localparam int N_SETTINGS    = 11;
  localparam int SETTING_ITEMS = 120;
  localparam int QUIET_SETTING = 8;
  localparam int SQUEEZE_SETTING = 9;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 30;
  localparam int STALL_LIMIT   = 4000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  chct_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  chct_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Our own copy of the hull, the registers and the running set flag.
  logic signed [COORD_BITS-1:0] hull_y [HULL_MAX];
  logic signed [COORD_BITS-1:0] hull_z [HULL_MAX];
  logic [VCNT_W-1:0]            hull_cnt = VCNT_RESET;
  logic [TOL_W-1:0]             hull_tol = TOL_RESET;
  logic                         set_all_in = 1'b1;
  chct_out_t                    verdict_q [$];

  // Polygon currently used to aim query points.
  int  poly_y [HULL_MAX];
  int  poly_z [HULL_MAX];
  int  poly_n;
  real poly_cy, poly_cz, poly_r;

  // Traffic shaping for the sender and the receiver.
  bit calm = 1'b0;
  bit tx_calm = 1'b0;
  bit hold_request = 1'b0;
  int rx_hold = 0;

  int errs = 0;
  int n_items = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_results = 0;
  int n_cfg = 0;

  // Directed stimulus rows.
  chct_in_t  dir_item [N_DIRECTED];
  logic      dir_typed [N_DIRECTED];
  chct_out_t dir_want [N_DIRECTED];

  // Register settings stepped through after the directed part.
  logic [VCNT_W-1:0] set_vc [N_SETTINGS] = '{5'd16, 5'd16, 5'd4, 5'd31, 5'd0, 5'd1, 5'd2,
                                             5'd17, 5'd3, 5'd8, 5'd12};
  int set_tol [N_SETTINGS] = '{0, 65535, 3277, -1, -1, -1, -1, -1, 3277, -1, -1};

  convex_hull_containment_test dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic chct_in_t pack_item(logic f, logic [VIDX_W-1:0] idx, int y, int z,
                                         logic last);
    chct_in_t it;
    it.func         = f;
    it.vertex_index = idx;
    it.coord_y      = y[COORD_BITS-1:0];
    it.coord_z      = z[COORD_BITS-1:0];
    it.last_point   = last;
    return it;
  endfunction

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Exact edge test: the point is outside once any edge turn drops below -tolerance.
  function automatic logic point_in_hull(logic signed [COORD_BITS-1:0] py,
                                         logic signed [COORD_BITS-1:0] pz);
    longint vy, vz, ey, ez, dy, dz, turn;
    int n, j;
    n = (hull_cnt > HULL_MAX) ? HULL_MAX : int'(hull_cnt);
    for (int i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      vy = longint'(hull_y[i]);
      vz = longint'(hull_z[i]);
      ey = longint'(hull_y[j]) - vy;
      ez = longint'(hull_z[j]) - vz;
      dy = longint'(py) - vy;
      dz = longint'(pz) - vz;
      turn = ey * dz - ez * dy + longint'(hull_tol);
      if (turn < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Update our state for an accepted item and queue the verdict it should produce.
  task automatic apply_item(chct_in_t it, logic typed, chct_out_t want);
    chct_out_t res;
    if (it.func == FUNC_LOAD) begin
      hull_y[it.vertex_index] = it.coord_y;
      hull_z[it.vertex_index] = it.coord_z;
      n_loads++;
    end else begin
      res.inside_res = point_in_hull(it.coord_y, it.coord_z);
      if (!res.inside_res) set_all_in = 1'b0;
      res.all_inside = set_all_in;
      res.set_done   = it.last_point;
      if (it.last_point) set_all_in = 1'b1;
      if (typed) res = want;
      verdict_q = {verdict_q, res};
      n_queries++;
    end
    n_items++;
  endtask

  function automatic int pick_gap();
    int roll;
    if (tx_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item, hold it until taken, then account for it.
  task automatic send_item(chct_in_t it, logic typed, chct_out_t want);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_item(it, typed, want);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_VERTEX_COUNT) hull_cnt = val[VCNT_W-1:0];
    else if (idx == REG_TOLERANCE) hull_tol = val[TOL_W-1:0];
    n_cfg++;
  endtask

  // Wait for every queued verdict, then let a possible trailing load settle.
  task automatic drain();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Load a roughly regular counter-clockwise polygon into slots 0..n-1.
  task automatic new_polygon(int n);
    int roll, y, z;
    real a;
    roll = $urandom_range(0, 9);
    if (roll < 3) poly_r = real'($urandom_range(16, 256));
    else if (roll < 8) poly_r = real'($urandom_range(256, 4096));
    else poly_r = real'($urandom_range(4096, 16000));
    poly_cy = real'(int'($urandom_range(0, 40000)) - 20000);
    poly_cz = real'(int'($urandom_range(0, 40000)) - 20000);
    poly_n  = n;
    for (int k = 0; k < n; k++) begin
      a = 6.283185307 * (real'(k) + real'($urandom_range(0, 70)) / 100.0) / real'(n);
      y = clamp_coord(int'(poly_cy + poly_r * $cos(a)));
      z = clamp_coord(int'(poly_cz + poly_r * $sin(a)));
      poly_y[k] = y;
      poly_z[k] = z;
      send_item(pack_item(FUNC_LOAD, k[VIDX_W-1:0], y, z, 1'($urandom_range(0, 1))),
                1'b0, '0);
    end
  endtask

  // Query points aimed inside, along the edges, around the polygon, or anywhere.
  task automatic random_query();
    int roll, k, k2, y, z;
    int corner [4];
    real t;
    corner = '{-32768, 32767, -32767, 0};
    roll = $urandom_range(0, 99);
    k  = $urandom_range(0, poly_n - 1);
    k2 = (k + 1) % poly_n;
    t  = real'($urandom_range(0, 1000)) / 1000.0;
    if (roll < 30) begin
      y = int'(poly_cy + t * (real'(poly_y[k]) - poly_cy));
      z = int'(poly_cz + t * (real'(poly_z[k]) - poly_cz));
    end else if (roll < 60) begin
      y = int'(real'(poly_y[k]) + t * real'(poly_y[k2] - poly_y[k]))
          + int'($urandom_range(0, 16)) - 8;
      z = int'(real'(poly_z[k]) + t * real'(poly_z[k2] - poly_z[k]))
          + int'($urandom_range(0, 16)) - 8;
    end else if (roll < 75) begin
      y = int'(poly_cy + 1.5 * poly_r * real'(int'($urandom_range(0, 2000)) - 1000) / 1000.0);
      z = int'(poly_cz + 1.5 * poly_r * real'(int'($urandom_range(0, 2000)) - 1000) / 1000.0);
    end else if (roll < 88) begin
      y = int'($urandom_range(0, 65535)) - 32768;
      z = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      y = corner[$urandom_range(0, 3)];
      z = corner[$urandom_range(0, 3)];
    end
    send_item(pack_item(FUNC_QUERY, VIDX_W'($urandom_range(0, 15)), clamp_coord(y),
                        clamp_coord(z), $urandom_range(0, 5) == 0), 1'b0, '0);
  endtask

  // Receiver: random short and long stalls, plus one long hold-off on request.
  always @(negedge clk) begin : rx_pacing
    int roll;
    if (hold_request) begin
      rx_hold = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        rx_hold = $urandom_range(1, 3);
        out_ready <= 1'b0;
      end else if (roll < 12) begin
        rx_hold = $urandom_range(10, 40);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest queued verdict.
  always @(posedge clk) begin : check_results
    chct_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with none expected: inside=%b all=%b done=%b", $time,
                 out_data.inside_res, out_data.all_inside, out_data.set_done);
        errs++;
      end else begin
        want = verdict_q.pop_front();
        n_results++;
        if (out_data !== want) begin
          $display("%0t: result mismatch: expected inside=%b all=%b done=%b, actual inside=%b all=%b done=%b",
                   $time, want.inside_res, want.all_inside, want.set_done,
                   out_data.inside_res, out_data.all_inside, out_data.set_done);
          errs++;
        end
      end
    end
  end

  // Watchdog: give up when no channel has moved an item for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: timeout, nothing moved for %0d cycles", $time, STALL_LIMIT);
    $display("convex_hull_containment_test verification failed");
    $finish;
  end

  initial begin : main_seq
    int n, base, tolv;
    for (int i = 0; i < HULL_MAX; i++) begin
      hull_y[i] = '0;
      hull_z[i] = '0;
    end

    // Directed part: extreme triangle in slots 0..2, every other slot written once.
    dir_item[0] = pack_item(FUNC_LOAD, 4'd0, -32768, -32768, 1'b0);
    dir_item[1] = pack_item(FUNC_LOAD, 4'd1, 32767, -32768, 1'b1);
    dir_item[2] = pack_item(FUNC_LOAD, 4'd2, -32768, 32767, 1'b0);
    for (int k = 3; k < HULL_MAX; k++)
      dir_item[k] = pack_item(FUNC_LOAD, k[VIDX_W-1:0], k * 2048 - 16384, 32767 - k * 4096,
                              k[0]);
    // A vertex is inside; the far corner is out and clears the set flag.
    dir_item[16] = pack_item(FUNC_QUERY, 4'd0, -32768, -32768, 1'b0);
    dir_want[16] = '{1'b1, 1'b1, 1'b0};
    dir_item[17] = pack_item(FUNC_QUERY, 4'd0, 32767, 32767, 1'b0);
    dir_want[17] = '{1'b0, 1'b0, 1'b0};
    dir_item[18] = pack_item(FUNC_QUERY, 4'd0, -32768, -32768, 1'b1);
    dir_want[18] = '{1'b1, 1'b0, 1'b1};
    // After the set ends the flag starts over; a point on an edge is inside.
    dir_item[19] = pack_item(FUNC_QUERY, 4'd0, -32768, 0, 1'b0);
    dir_want[19] = '{1'b1, 1'b1, 1'b0};
    dir_item[20] = pack_item(FUNC_QUERY, 4'd0, 0, 0, 1'b0);
    dir_item[21] = pack_item(FUNC_QUERY, 4'd0, -1, -1, 1'b0);
    dir_item[22] = pack_item(FUNC_QUERY, 4'd0, 32767, -32768, 1'b1);
    dir_item[23] = pack_item(FUNC_QUERY, 4'd15, -32768, 32767, 1'b0);
    dir_item[24] = pack_item(FUNC_QUERY, 4'd10, 32767, -32767, 1'b1);
    for (int k = 0; k < N_DIRECTED; k++) dir_typed[k] = (k >= 16 && k <= 19);
    for (int k = 0; k < 16; k++) dir_want[k] = '0;
    for (int k = 20; k < N_DIRECTED; k++) dir_want[k] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < N_DIRECTED; k++) send_item(dir_item[k], dir_typed[k], dir_want[k]);

    // Random part, one register setting after another.
    for (int p = 0; p < N_SETTINGS; p++) begin
      @(negedge clk);
      in_valid <= 1'b0;
      drain();
      write_reg(REG_VERTEX_COUNT, {CFG_DATA_W'($urandom_range(0, 2047)) << VCNT_W} | set_vc[p]);
      if (set_tol[p] >= 0) tolv = set_tol[p];
      else if ($urandom_range(0, 1)) tolv = $urandom_range(0, 4000);
      else tolv = $urandom_range(0, 65535);
      write_reg(REG_TOLERANCE, tolv[CFG_DATA_W-1:0]);
      write_reg(p[0] ? REG_SPARE_B : REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 65535)));
      calm    = (p == QUIET_SETTING);
      tx_calm = (p == QUIET_SETTING) || (p == SQUEEZE_SETTING);
      if (p == SQUEEZE_SETTING) hold_request = 1'b1;
      @(negedge clk);
      cfg_valid <= 1'b0;

      n = (hull_cnt > HULL_MAX) ? HULL_MAX : int'(hull_cnt);
      if (n < 3) n = 3;
      new_polygon(n);
      base = n_items;
      while (n_items - base < SETTING_ITEMS) begin
        tolv = $urandom_range(0, 99);
        if (tolv < 90) begin
          random_query();
        end else if (tolv < 95) begin
          // Stray vertex write that bends the polygon out of shape.
          send_item(pack_item(FUNC_LOAD, VIDX_W'($urandom_range(0, 15)),
                              int'($urandom_range(0, 65535)) - 32768,
                              int'($urandom_range(0, 65535)) - 32768, 1'($urandom_range(0, 1))),
                    1'b0, '0);
        end else begin
          new_polygon(n);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    drain();

    $display("Covered %0d items (%0d vertex loads, %0d point queries) over %0d register settings.",
             n_items, n_loads, n_queries, N_SETTINGS + 1);
    $display("Checked %0d results after %0d register writes; %0d mismatches.",
             n_results, n_cfg, errs);
    if (errs == 0)
      $display("convex_hull_containment_test verification clean");
    else
      $display("convex_hull_containment_test verification failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/chct_pkg.sv
hw/rtl/chct_seq.sv
hw/rtl/chct_datapath.sv
hw/rtl/convex_hull_containment_test.sv
hw/rtl/chct_checker.sv
verif/tb_top.sv
